// ===== sv/motion_stall_detector_core_macros.svh =====
// Assertion macros shared by the stall detector RTL.
`ifndef MOTION_STALL_DETECTOR_CORE_MACROS_SVH
`define MOTION_STALL_DETECTOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MSD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stall detector check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define MSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stall detector check failed");

`endif

// ===== sv/msd_pkg.sv =====
// Types and constants for the motion stall detector.
package msd_pkg;

    localparam int unsigned POS_W     = 16;
    localparam int unsigned HEAD_W    = 12;
    localparam int unsigned PWIN_W    = 10;
    localparam int unsigned HWIN_W    = 11;
    localparam int unsigned STALL_W   = 16;
    localparam int unsigned PERIOD_W  = 10;
    localparam int unsigned SAMPLE_W  = 11;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned PHASE_W   = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_WINDOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALL_TICKS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESAMPLE_PERIOD = 2'd3;

    // Register values after reset.
    localparam logic [PWIN_W-1:0]   RST_POSITION_WINDOW = 10'd10;
    localparam logic [HWIN_W-1:0]   RST_HEADING_WINDOW  = 11'd30;
    localparam logic [STALL_W-1:0]  RST_STALL_TICKS     = 16'd500;
    localparam logic [PERIOD_W-1:0] RST_RESAMPLE_PERIOD = 10'd50;

    // Phase codes as reported on the result channel.
    localparam logic [PHASE_W-1:0] PHASE_CAPTURE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_MONITOR = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_JAMMED  = 2'd2;

    localparam logic [STALL_W-1:0]  STILL_MAX  = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    typedef enum logic [2:0] {
        ST_CAPTURE = 3'b001,
        ST_MONITOR = 3'b010,
        ST_JAMMED  = 3'b100
    } state_t;

endpackage

// ===== sv/motion_stall_detector_core.sv =====
// Top level of the motion stall detector: one pose sample in, one status result out.
// The detector watches a stream of pose samples and declares a jam when the
// pose stays inside a small window for a configurable number of active ticks.
// Each accepted request produces exactly one result: fire is high when the
// tick ran in the jammed phase, phase is the phase after the tick, and
// still_ticks is the consecutive still count after the tick. Requests with
// active low leave all state untouched. A request is captured in an input
// register and evaluated in the next cycle against the stored reference pose;
// three subtract-and-compare pairs and the saturating counters settle
// combinationally and the result lands in an output register. The throughput
// is one request per clock; the only thing that slows it down is out_ready
// held low, which backs up through the two registers to in_ready. Configuration
// writes take effect at once and are meant to happen while no request is in
// flight.
`include "motion_stall_detector_core_macros.svh"

module motion_stall_detector_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_wr_en,
    input  logic [msd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [msd_pkg::CFG_DAT_W-1:0]         cfg_data,
    // Request channel.
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  active,
    input  logic signed [msd_pkg::POS_W-1:0]      position_x,
    input  logic signed [msd_pkg::POS_W-1:0]      position_y,
    input  logic signed [msd_pkg::HEAD_W-1:0]     heading,
    // Result channel.
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  fire,
    output logic [msd_pkg::PHASE_W-1:0]           phase,
    output logic [msd_pkg::STALL_W-1:0]           still_ticks
);

    import msd_pkg::*;

    // Configuration registers.
    logic [PWIN_W-1:0]   pos_window_reg;
    logic [HWIN_W-1:0]   head_window_reg;
    logic [STALL_W-1:0]  stall_ticks_reg;
    logic [PERIOD_W-1:0] period_reg;

    // Input stage.
    logic                     in_valid_reg;
    logic                     active_reg;
    logic signed [POS_W-1:0]  x_reg;
    logic signed [POS_W-1:0]  y_reg;
    logic signed [HEAD_W-1:0] h_reg;

    // Detector state.
    state_t                   state_reg,  state_next;
    logic [STALL_W-1:0]       still_reg,  still_next;
    logic [SAMPLE_W-1:0]      sample_reg, sample_next;
    logic signed [POS_W-1:0]  ref_x_reg,  ref_x_next;
    logic signed [POS_W-1:0]  ref_y_reg,  ref_y_next;
    logic signed [HEAD_W-1:0] ref_h_reg,  ref_h_next;
    logic                     fire_next;

    // Output stage.
    logic                 out_valid_reg;
    logic                 fire_reg;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [STALL_W-1:0]   still_out_reg;

    logic advance;

    // Deltas against the reference pose.
    logic signed [POS_W:0]  dx_s, dy_s;
    logic signed [HEAD_W:0] dh_s;
    logic [POS_W:0]         dx_abs, dy_abs;
    logic [HEAD_W:0]        dh_abs;
    logic [POS_W-1:0]       dx_mag, dy_mag;
    logic [HEAD_W-1:0]      dh_mag;
    logic [POS_W-1:0]       pos_win_ext;
    logic [HEAD_W-1:0]      head_win_ext;
    logic                   inside_all, outside_all;

    // The evaluation stage moves whenever the output register is free or drained.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_window_reg  <= RST_POSITION_WINDOW;
            head_window_reg <= RST_HEADING_WINDOW;
            stall_ticks_reg <= RST_STALL_TICKS;
            period_reg      <= RST_RESAMPLE_PERIOD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POSITION_WINDOW: pos_window_reg  <= cfg_data[PWIN_W-1:0];
                REG_HEADING_WINDOW:  head_window_reg <= cfg_data[HWIN_W-1:0];
                REG_STALL_TICKS:     stall_ticks_reg <= cfg_data[STALL_W-1:0];
                REG_RESAMPLE_PERIOD: period_reg      <= cfg_data[PERIOD_W-1:0];
                default:             ;
            endcase
        end
    end

    // Input register: control bit reset, payload loaded on each accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            active_reg <= active;
            x_reg      <= position_x;
            y_reg      <= position_y;
            h_reg      <= heading;
        end
    end

    // Plain signed differences, no heading wrap-around. The magnitudes always
    // fit one bit narrower than the difference.
    always_comb
    begin
        dx_s   = {x_reg[POS_W-1], x_reg} - {ref_x_reg[POS_W-1], ref_x_reg};
        dy_s   = {y_reg[POS_W-1], y_reg} - {ref_y_reg[POS_W-1], ref_y_reg};
        dh_s   = {h_reg[HEAD_W-1], h_reg} - {ref_h_reg[HEAD_W-1], ref_h_reg};
        dx_abs = dx_s[POS_W]  ? (-dx_s) : dx_s;
        dy_abs = dy_s[POS_W]  ? (-dy_s) : dy_s;
        dh_abs = dh_s[HEAD_W] ? (-dh_s) : dh_s;
        dx_mag = dx_abs[POS_W-1:0];
        dy_mag = dy_abs[POS_W-1:0];
        dh_mag = dh_abs[HEAD_W-1:0];
        pos_win_ext  = {{(POS_W-PWIN_W){1'b0}}, pos_window_reg};
        head_win_ext = {{(HEAD_W-HWIN_W){1'b0}}, head_window_reg};
        inside_all  = (dx_mag < pos_win_ext) && (dy_mag < pos_win_ext)
                      && (dh_mag < head_win_ext);
        outside_all = (dx_mag > pos_win_ext) && (dy_mag > pos_win_ext)
                      && (dh_mag > head_win_ext);
    end

    // Next state for one active tick.
    always_comb
    begin
        state_next  = state_reg;
        still_next  = still_reg;
        sample_next = sample_reg;
        ref_x_next  = ref_x_reg;
        ref_y_next  = ref_y_reg;
        ref_h_next  = ref_h_reg;
        fire_next   = 1'b0;

        if (active_reg)
        begin
            case (state_reg)
                ST_MONITOR:
                begin
                    if (sample_reg != SAMPLE_MAX)
                    begin
                        sample_next = sample_reg + 1'b1;
                    end
                    if (inside_all)
                    begin
                        if (still_reg != STILL_MAX)
                        begin
                            still_next = still_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        still_next = '0;
                    end
                    // Refresh the reference once the sample counter passes the period.
                    if (sample_next > {{(SAMPLE_W-PERIOD_W){1'b0}}, period_reg})
                    begin
                        sample_next = '0;
                        ref_x_next  = x_reg;
                        ref_y_next  = y_reg;
                        ref_h_next  = h_reg;
                    end
                    if (still_next >= stall_ticks_reg)
                    begin
                        state_next = ST_JAMMED;
                        still_next = '0;
                    end
                end
                ST_JAMMED:
                begin
                    fire_next = 1'b1;
                    if (outside_all)
                    begin
                        state_next = ST_CAPTURE;
                    end
                end
                default:
                begin
                    // Capture the reference pose and start monitoring.
                    ref_x_next = x_reg;
                    ref_y_next = y_reg;
                    ref_h_next = h_reg;
                    state_next = ST_MONITOR;
                end
            endcase
        end
    end

    always_comb
    begin
        case (state_next)
            ST_MONITOR: phase_next = PHASE_MONITOR;
            ST_JAMMED:  phase_next = PHASE_JAMMED;
            default:    phase_next = PHASE_CAPTURE;
        endcase
    end

    // State commits only when the request actually moves into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CAPTURE;
            still_reg  <= '0;
            sample_reg <= '0;
            ref_x_reg  <= '0;
            ref_y_reg  <= '0;
            ref_h_reg  <= '0;
        end
        else if (in_valid_reg && advance)
        begin
            state_reg  <= state_next;
            still_reg  <= still_next;
            sample_reg <= sample_next;
            ref_x_reg  <= ref_x_next;
            ref_y_reg  <= ref_y_next;
            ref_h_reg  <= ref_h_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
        begin
            fire_reg      <= fire_next;
            phase_reg     <= phase_next;
            still_out_reg <= still_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign fire        = fire_reg;
    assign phase       = phase_reg;
    assign still_ticks = still_out_reg;

    // A firing tick ends either still jammed or back in capture.
    `MSD_ASSERT_SAME(a_fire_phase, out_valid && fire,
                     phase == PHASE_JAMMED || phase == PHASE_CAPTURE)
    // The still count is cleared on entering the jammed phase and stays clear there.
    `MSD_ASSERT_SAME(a_jammed_still_zero, out_valid && phase == PHASE_JAMMED, still_ticks == '0)
    // The sample counter is reset as soon as it passes the period, so it never exceeds 1024.
    `MSD_ASSERT_SAME(a_sample_bound, sample_reg[SAMPLE_W-1], sample_reg[SAMPLE_W-2:0] == '0)
    // A stalled request in the input register keeps its place and its state untouched.
    `MSD_ASSERT_NEXT(a_stall_holds, in_valid_reg && !advance,
                     in_valid_reg && $stable(state_reg) && $stable(still_reg))

endmodule
